@@ hw/rtl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared command codes, round constants, initial hash words and helpers.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_byte;   // store the request's byte at the fill position
		logic pad_byte;     // store a padding byte (0x80 or zero) at the fill position
		logic pad_first;    // padding byte is 0x80
		logic write_length; // store the bit length in words 14 and 15
		logic clear_block;  // zero the whole block (second padding block)
		logic start_comp;   // begin a compression
		logic round_step;   // run one round
		logic finish_comp;  // add the working variables into the chain
		logic reinit;       // back to the initial value for the next message
	} sha256_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] fill_count;
		logic       last_round;
	} sha256_status_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ hw/rtl/sha256_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round unit, chaining value and bit length.
// ----------------------------------------------------------------------------
module sha256_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sha256_pkg::sha256_cmd_t   cmd,
	input  logic [7:0]                data_byte,
	input  logic [2:0]                read_index,
	output logic [31:0]               read_word,
	output sha256_pkg::sha256_status_t status
);

	logic [31:0] block_q [16];
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [63:0] bitlen_q;

	logic [7:0]  byte_val;
	logic [3:0]  widx;
	logic [4:0]  bsh;
	logic [31:0] s0, s1, w_new, t1, t2, ch, maj, e, a;

	assign byte_val = cmd.write_byte ? data_byte : (cmd.pad_first ? 8'h80 : 8'h00);
	assign widx     = fill_q[5:2];
	assign bsh      = 5'd24 - {fill_q[1:0], 3'b000};

	// Schedule expansion and round logic.
	always_comb begin
		s0    = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
		        ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		a     = v_q[0];
		e     = v_q[4];
		ch    = (e & v_q[5]) ^ (~e & v_q[6]);
		maj   = (a & v_q[1]) | (v_q[1] & v_q[2]) | (v_q[2] & a);
		t1    = v_q[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
		        ^ sha256_pkg::rotr(e, 25)) + ch + sha256_pkg::ROUND_K[round_q] + w_q[0];
		t2    = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
		        + maj;
	end

	// Block buffer; it takes no reset, every read word is written first.
	always_ff @(posedge clk) begin
		if (cmd.clear_block) begin
			for (int i = 0; i < 16; i++) block_q[i] <= '0;
		end else if (cmd.write_length) begin
			block_q[14] <= bitlen_q[63:32];
			block_q[15] <= bitlen_q[31:0];
		end else if (cmd.write_byte || cmd.pad_byte) begin
			block_q[widx] <= (block_q[widx] & ~(32'hff << bsh))
			                 | ({24'd0, byte_val} << bsh);
		end
	end

	// Schedule window and working variables.
	always_ff @(posedge clk) begin
		if (cmd.start_comp) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block_q[i];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round_step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			for (int i = 1; i < 8; i++) v_q[i] <= v_q[i - 1];
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	// Control state: chain, fill count, bit length and round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_H[i];
			fill_q   <= '0;
			round_q  <= '0;
			bitlen_q <= '0;
		end else begin
			if (cmd.reinit) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_H[i];
				bitlen_q <= '0;
				fill_q   <= '0;
			end else begin
				if (cmd.finish_comp) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.write_byte) bitlen_q <= bitlen_q + 64'd8;
				if (cmd.write_byte || cmd.pad_byte) fill_q <= fill_q + 6'd1;
			end
			if (cmd.start_comp) round_q <= '0;
			else if (cmd.round_step) round_q <= round_q + 6'd1;
		end
	end

	assign read_word         = h_q[read_index];
	assign status.fill_count = fill_q;
	assign status.last_round = (round_q == 6'd63);

endmodule

@@ hw/rtl/sha256_controller.sv @@
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compression and digest read-out.
// ----------------------------------------------------------------------------
module sha256_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 out_index,
	input  sha256_pkg::sha256_status_t status,
	output sha256_pkg::sha256_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic       final_q;  // compression in flight is the length block
	logic       second_q; // padding wraps into a second block
	logic [2:0] idx_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_index = idx_q;

	// Command decode.
	always_comb begin
		cmd            = '0;
		cmd.write_byte = accept && (command == sha256_pkg::CMD_ABSORB);
		case (state_q)
			ST_IDLE: begin
				if (accept && command == sha256_pkg::CMD_FINISH) begin
					cmd.pad_byte  = 1'b1;
					cmd.pad_first = 1'b1;
				end
			end
			ST_PAD: begin
				// A wrapped fill count ends the first of two padding blocks; on the
				// cleared second block it marks where the length goes.
				if (status.fill_count == 6'd0 && second_q) begin
					cmd.start_comp = 1'b1;
				end else if ((status.fill_count inside {6'd0, 6'd56}) && !second_q) begin
					cmd.write_length = 1'b1;
				end else begin
					cmd.pad_byte = 1'b1;
				end
			end
			ST_LEN:   cmd.start_comp  = 1'b1;
			ST_ROUND: cmd.round_step  = 1'b1;
			ST_ADD: begin
				cmd.finish_comp = 1'b1;
				cmd.clear_block = !final_q && second_q;
			end
			ST_OUT:   cmd.reinit      = out_ready && (idx_q == 3'd7);
			default:  cmd             = '0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && command == sha256_pkg::CMD_FINISH) begin
						state_q  <= ST_PAD;
						second_q <= (status.fill_count > 6'd55);
					end else if (cmd.write_byte && status.fill_count == 6'd63) begin
						state_q <= ST_LEN;
						final_q <= 1'b0;
					end
				end
				ST_PAD: begin
					if (cmd.start_comp) begin
						state_q <= ST_ROUND;
						final_q <= 1'b0;
					end else if (cmd.write_length) begin
						state_q <= ST_LEN;
						final_q <= 1'b1;
					end
				end
				ST_LEN:   state_q <= ST_ROUND;
				ST_ROUND: if (status.last_round) state_q <= ST_ADD;
				ST_ADD: begin
					if (final_q) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
					end else if (second_q) begin
						state_q  <= ST_PAD;
						second_q <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/sha256_message_digest_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message digest core
// Byte-wide SHA-256 engine emitting the eight digest words on finish.
// ----------------------------------------------------------------------------
// An absorb request is taken while idle; the 64th byte of a block starts a
// compression (load, 64 rounds at one per cycle through the single round
// unit, chain add) during which no request is taken. A finish request pads
// byte by byte up to the length field, compresses, and then presents the
// eight digest words one per cycle while the receiver is ready; with more
// than 55 pending bytes a second block (pad, zero, length) adds another
// compression.
module sha256_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha256_pkg::sha256_cmd_t    cmd;
	sha256_pkg::sha256_status_t status;

	sha256_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_index (word_index),
		.status    (status),
		.cmd       (cmd)
	);

	sha256_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.read_index (word_index),
		.read_word  (digest_word),
		.status     (status)
	);

	assign last_word = (word_index == 3'd7);

	// A request is never taken while the digest is being presented.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("request taken during read-out");

	// After the final word the block is idle again.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> (in_ready && !out_valid))
		else $error("not idle after digest");

	// Words advance by one per accepted digest word.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> (out_valid &&
		word_index == $past(word_index) + 3'd1)) else $error("word index skipped");

endmodule
